>>> sv/pol_pkg.sv
// Shared types and codes for the positional ordered list block.
`timescale 1ns / 1ps

package pol_pkg;

  // Operation codes carried in the kind field of a request.
  typedef enum logic [2:0] {
    K_INS_FRONT = 3'd0,
    K_INS_BACK  = 3'd1,
    K_INS_AT    = 3'd2,
    K_DEL_FRONT = 3'd3,
    K_DEL_BACK  = 3'd4,
    K_DEL_AT    = 3'd5,
    K_SEARCH    = 3'd6
  } pol_kind_t;

  // Status codes returned in each response.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_INVALID  = 3'd2,
    ST_RANGE    = 3'd3,
    ST_FULL     = 3'd4,
    ST_NOTFOUND = 3'd5
  } pol_status_t;

  // Request payload.
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic [4:0]         position;
  } pol_req_t;

  // Response payload.
  typedef struct packed {
    logic [2:0] status;
    logic [4:0] found_position;
    logic [4:0] entry_count;
  } pol_rsp_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_REPLY
  } pol_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic exec_op;
    logic start_scan;
    logic scan_step;
    logic reply;
  } pol_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_search;
    logic rsp_free;
    logic scan_done;
  } pol_sts_t;

endpackage

>>> sv/pol_ctrl.sv
// Controller state machine for the positional ordered list.
`timescale 1ns / 1ps

module pol_ctrl
  import pol_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  pol_sts_t sts,
  output pol_cmd_t cmd
);

  pol_state_t state;
  pol_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.is_search) state_next = S_SCAN;
        else if (sts.rsp_free) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = S_REPLY;
      end
      S_REPLY: begin
        if (sts.rsp_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready    = 1'b1;
        cmd.load_req = req_valid;
      end
      S_EXEC: begin
        cmd.start_scan = sts.is_search;
        cmd.exec_op    = !sts.is_search && sts.rsp_free;
      end
      S_SCAN: begin
        cmd.scan_step = !sts.scan_done;
      end
      S_REPLY: begin
        cmd.reply = sts.rsp_free;
      end
      default: begin
        cmd       = '0;
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> sv/pol_dp.sv
// Datapath of the positional ordered list: cell row, occupancy, search scan, response register.
`timescale 1ns / 1ps

module pol_dp
  import pol_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  pol_cmd_t cmd,
  output pol_sts_t sts,
  input  pol_req_t req,
  output pol_rsp_t rsp,
  output logic     rsp_valid,
  input  logic     rsp_ready
);

  localparam int CW   = $clog2(DEPTH + 2);
  localparam int CMPW = (CW > 5) ? CW : 5;
  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pol_req_t        req_reg;
  logic [31:0]     cells [DEPTH];
  logic [31:0]     prev_c [DEPTH];
  logic [31:0]     succ_c [DEPTH];
  logic            match [DEPTH];
  logic [CW-1:0]   occ;
  logic [CW-1:0]   occ_next;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   idx_c;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] occ_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] cnt_ext_next;
  logic [CMPW-1:0] occ_next_ext;
  logic [CMPW-1:0] pos_less1;
  logic            do_ins;
  logic            do_del;
  logic            full;
  logic            scan_hit;
  logic [2:0]      status_c;

  // Transaction capture.
  always_ff @(posedge clk) begin
    if (cmd.load_req) req_reg <= req;
  end

  // Operation decode and checks against the current occupancy.
  always_comb begin
    pos_ext   = CMPW'(req_reg.position);
    occ_ext   = CMPW'(occ);
    pos_less1 = pos_ext - CMPW'(1);
    full      = (occ == CW'(DEPTH));
    status_c  = ST_OK;
    do_ins    = 1'b0;
    do_del    = 1'b0;
    idx_c     = '0;
    unique case (req_reg.kind)
      K_INS_FRONT: begin
        if (full) status_c = ST_FULL;
        else do_ins = 1'b1;
      end
      K_INS_BACK: begin
        if (full) status_c = ST_FULL;
        else begin
          do_ins = 1'b1;
          idx_c  = occ;
        end
      end
      K_INS_AT: begin
        if (pos_ext == '0) status_c = ST_INVALID;
        else if (pos_ext > occ_ext + CMPW'(1)) status_c = ST_RANGE;
        else if (full) status_c = ST_FULL;
        else begin
          do_ins = 1'b1;
          idx_c  = CW'(pos_less1);
        end
      end
      K_DEL_FRONT: begin
        if (occ == '0) status_c = ST_EMPTY;
        else do_del = 1'b1;
      end
      K_DEL_BACK: begin
        if (occ == '0) status_c = ST_EMPTY;
        else begin
          do_del = 1'b1;
          idx_c  = occ - CW'(1);
        end
      end
      K_DEL_AT: begin
        if (pos_ext == '0) status_c = ST_INVALID;
        else if (occ == '0) status_c = ST_EMPTY;
        else if (pos_ext > occ_ext) status_c = ST_RANGE;
        else begin
          do_del = 1'b1;
          idx_c  = CW'(pos_less1);
        end
      end
      default: status_c = ST_OK;
    endcase
  end

  always_comb begin
    occ_next = occ;
    if (do_ins) occ_next = occ + CW'(1);
    else if (do_del) occ_next = occ - CW'(1);
  end

  // Neighbor taps of the cell row.
  for (genvar i = 0; i < DEPTH; i++) begin : g_taps
    if (i > 0) begin : g_prev
      assign prev_c[i] = cells[i-1];
    end else begin : g_prev0
      assign prev_c[i] = '0;
    end
    if (i < DEPTH - 1) begin : g_succ
      assign succ_c[i] = cells[i+1];
    end else begin : g_succ_last
      assign succ_c[i] = '0;
    end
  end

  // Each cell shifts toward the back on insert or toward the front on delete,
  // and registers its own compare against the searched value.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] I = CW'(i);
    always_ff @(posedge clk) begin
      if (cmd.exec_op) begin
        if (do_ins) begin
          if (I == idx_c) cells[i] <= req_reg.value;
          else if ((I > idx_c) && (I <= occ)) cells[i] <= prev_c[i];
        end else if (do_del) begin
          if ((I >= idx_c) && ((I + CW'(1)) < occ)) cells[i] <= succ_c[i];
        end
      end
      if (cmd.start_scan) match[i] <= (cells[i] == req_reg.value);
    end
  end

  // Occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.exec_op) begin
      occ <= occ_next;
    end
  end

  // Scan counter walks the registered match bits from the front.
  always_ff @(posedge clk) begin
    if (cmd.start_scan) cnt <= '0;
    else if (cmd.scan_step) cnt <= cnt + CW'(1);
  end

  assign scan_hit     = (cnt != occ);
  assign cnt_ext      = CMPW'(cnt);
  assign cnt_ext_next = cnt_ext + CMPW'(1);
  assign occ_next_ext = CMPW'(occ_next);

  // Response register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.exec_op || cmd.reply) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_op) begin
      rsp.status         <= status_c;
      rsp.found_position <= '0;
      rsp.entry_count    <= occ_next_ext[4:0];
    end else if (cmd.reply) begin
      rsp.status         <= scan_hit ? ST_OK : ST_NOTFOUND;
      rsp.found_position <= scan_hit ? cnt_ext_next[4:0] : 5'd0;
      rsp.entry_count    <= occ_ext[4:0];
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.is_search = (req_reg.kind == K_SEARCH);
    sts.rsp_free  = !rsp_valid || rsp_ready;
    sts.scan_done = (cnt == occ) || match[cnt[IW-1:0]];
  end

endmodule

>>> sv/positional_ordered_list.sv
// Top level of the positional ordered list: controller, datapath and checks.
//
// A bounded ordered list of up to DEPTH signed 32-bit values, addressed by
// 1-based position. Each request transaction on the req channel carries one
// operation (insert front/back/at, delete front/back/at, search) and gives
// exactly one response transaction on the rsp channel with a status, the
// position of the first match on a search, and the entry count afterward.
// Both channels use valid/ready handshakes.
// Order of work: a non-search operation is committed in the EXEC state once
// the response register is free; a search registers its compare bits in EXEC,
// walks them in SCAN and writes its response in REPLY once the register is free.
// The controller handles one request at a time, so it takes no new request
// before the last one is committed, and the search walks the registered compare
// bits one cell per cycle.
// The response register parts the two sides: a new request is taken while a
// response still waits, and its work holds until the response is taken.
// Reset empties the list at once; cell contents are not cleared.
`timescale 1ns / 1ps

module positional_ordered_list
  import pol_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  pol_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output pol_rsp_t rsp
);

  pol_cmd_t cmd;
  pol_sts_t sts;

  pol_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pol_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

  // A response is written only into a free response register.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec_op || cmd.reply) |-> sts.rsp_free)
    else $error("response written while register busy");

  // No new request is taken while one is being worked on.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while busy");

  // A completed commit always presents a response next cycle.
  a_rsp_after_commit: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec_op || cmd.reply) |=> rsp_valid)
    else $error("response missing after commit");

  // The reported count never exceeds the list bound.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((DEPTH > 31) || (rsp.entry_count <= 5'(DEPTH))))
    else $error("entry count beyond depth");

endmodule

>>> bench/positional_ordered_list_tb.sv
// Self-checking testbench for the positional ordered list block.
`timescale 1ns / 1ps

module positional_ordered_list_tb;
  import pol_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int RANDOM_ITEMS = 1150;
  localparam int REPORT_LIMIT = 10;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 30;
  // The kind code that the block ignores.
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  // Shadow copy of the list and the queue of responses it predicts.
  class list_scoreboard;
    logic signed [31:0] shadow_cells[$];
    pol_rsp_t           pending_replies[$];
    int                 mismatches;
    int                 requests_seen;

    function new();
      mismatches    = 0;
      requests_seen = 0;
    endfunction

    // Apply one accepted request to the shadow list and queue its response.
    function void note_request(pol_req_t r);
      pol_rsp_t e;
      int       held;
      held             = shadow_cells.size();
      e                = '0;
      e.status         = ST_OK;
      e.found_position = '0;
      case (r.kind)
        K_INS_FRONT: begin
          if (held >= LIST_DEPTH) e.status = ST_FULL;
          else shadow_cells.push_front(r.value);
        end
        K_INS_BACK: begin
          if (held >= LIST_DEPTH) e.status = ST_FULL;
          else shadow_cells.push_back(r.value);
        end
        K_INS_AT: begin
          if (r.position == 0) e.status = ST_INVALID;
          else if (r.position > held + 1) e.status = ST_RANGE;
          else if (held >= LIST_DEPTH) e.status = ST_FULL;
          else shadow_cells.insert(r.position - 1, r.value);
        end
        K_DEL_FRONT: begin
          if (held == 0) e.status = ST_EMPTY;
          else void'(shadow_cells.pop_front());
        end
        K_DEL_BACK: begin
          if (held == 0) e.status = ST_EMPTY;
          else void'(shadow_cells.pop_back());
        end
        K_DEL_AT: begin
          if (r.position == 0) e.status = ST_INVALID;
          else if (held == 0) e.status = ST_EMPTY;
          else if (r.position > held) e.status = ST_RANGE;
          else shadow_cells.delete(r.position - 1);
        end
        K_SEARCH: begin
          e.status = ST_NOTFOUND;
          for (int i = 0; i < held; i++) begin
            if (shadow_cells[i] == r.value) begin
              e.status         = ST_OK;
              e.found_position = 5'(i + 1);
              break;
            end
          end
        end
        default: ;
      endcase
      e.entry_count = 5'(shadow_cells.size());
      pending_replies.push_back(e);
      requests_seen++;
    endfunction

    // Compare one accepted response with the oldest prediction.
    function void check_response(pol_rsp_t a);
      pol_rsp_t e;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected response: status %0d found %0d count %0d",
                   a.status, a.found_position, a.entry_count);
        return;
      end
      e = pending_replies.pop_front();
      if (a.status !== e.status || a.found_position !== e.found_position ||
          a.entry_count !== e.entry_count) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: status %0d/%0d found %0d/%0d count %0d/%0d (exp/got)",
                   e.status, a.status, e.found_position, a.found_position,
                   e.entry_count, a.entry_count);
      end
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  pol_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  pol_rsp_t rsp;

  list_scoreboard sb = new();
  int burst_left = 0;

  positional_ordered_list #(
    .DEPTH(LIST_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
      if (req_valid && req_ready) sb.note_request(req);
    end
  end

  // Offer one request transaction, with a random gap between bursts.
  task automatic issue(input logic [2:0] kind, input logic signed [31:0] value,
                       input logic [4:0] position);
    pol_req_t r;
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    r.kind     = kind;
    r.value    = value;
    r.position = position;
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  // Value to insert: a small pool makes duplicates for the search to sort out.
  function automatic logic signed [31:0] insert_value();
    if ($urandom_range(0, 9) < 4) return 32'($urandom_range(0, 7)) - 32'sd4;
    return $urandom;
  endfunction

  // Random request shaped by whether the list is being filled or drained.
  task automatic random_request(input bit grow);
    int                 held;
    int                 pick;
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic [4:0]         position;
    held     = sb.shadow_cells.size();
    pick     = $urandom_range(0, 99);
    value    = insert_value();
    position = 5'($urandom_range(0, 31));
    if (pick < 4) begin
      kind = 3'($urandom_range(0, 7));
    end else if (pick < 20) begin
      kind = K_SEARCH;
      if (held > 0 && $urandom_range(0, 9) < 6)
        value = sb.shadow_cells[$urandom_range(0, held - 1)];
    end else if (grow == ($urandom_range(0, 9) < 7)) begin
      case ($urandom_range(0, 2))
        0: kind = K_INS_FRONT;
        1: kind = K_INS_BACK;
        default: begin
          kind = K_INS_AT;
          if ($urandom_range(0, 9) < 8) position = 5'($urandom_range(1, held + 1));
        end
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0: kind = K_DEL_FRONT;
        1: kind = K_DEL_BACK;
        default: begin
          kind = K_DEL_AT;
          if ($urandom_range(0, 9) < 8)
            position = 5'($urandom_range(1, (held > 0) ? held : 1));
        end
      endcase
    end
    issue(kind, value, position);
  endtask

  // Response side: a changing stall pattern plus two long hold-offs.
  initial begin
    int cyc;
    int hold_left;
    int holds_done;
    int pattern;
    cyc        = 0;
    hold_left  = 0;
    holds_done = 0;
    pattern    = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (cyc % 64 == 0) pattern = $urandom_range(0, 3);
      if (hold_left == 0 && holds_done < 2 &&
          sb.requests_seen >= 200 + 500 * holds_done) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        case (pattern)
          0: rsp_ready <= 1'b1;
          1: rsp_ready <= ($urandom_range(0, 9) < 7);
          2: rsp_ready <= ($urandom_range(0, 9) < 3);
          default: rsp_ready <= cyc[1];
        endcase
      end
      cyc++;
      @(negedge clk);
    end
  end

  // Reset, directed cases, random traffic, then drain and report.
  initial begin
    bit grow;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Operations on an empty list.
    issue(K_SEARCH, 32'sd0, 5'd0);
    issue(K_DEL_FRONT, 32'sd0, 5'd0);
    issue(K_DEL_BACK, 32'sd0, 5'd0);
    issue(K_DEL_AT, 32'sd0, 5'd0);
    issue(K_DEL_AT, 32'sd0, 5'd1);
    issue(K_INS_AT, 32'sd1, 5'd0);
    issue(K_INS_AT, 32'sd1, 5'd2);
    // Build a short list with the value extremes.
    issue(K_INS_FRONT, 32'h8000_0000, 5'd0);
    issue(K_INS_BACK, 32'h7fff_ffff, 5'd0);
    issue(K_INS_AT, -32'sd1, 5'd3);
    issue(K_INS_AT, 32'sd0, 5'd1);
    issue(K_INS_AT, 32'sd5, 5'd2);
    issue(K_SEARCH, 32'h7fff_ffff, 5'd0);
    issue(K_SEARCH, 32'sd12345, 5'd0);
    issue(KIND_UNUSED, 32'hffff_ffff, 5'd31);
    // Positions past the end.
    issue(K_DEL_AT, 32'sd0, 5'd31);
    issue(K_DEL_AT, 32'sd0, 5'd6);
    issue(K_INS_AT, 32'sd9, 5'd7);
    // Take it apart again.
    issue(K_DEL_AT, 32'sd0, 5'd5);
    issue(K_DEL_AT, 32'sd0, 5'd2);
    issue(K_DEL_FRONT, 32'sd0, 5'd0);
    issue(K_DEL_BACK, 32'sd0, 5'd0);
    issue(K_SEARCH, 32'h8000_0000, 5'd0);
    issue(K_DEL_AT, 32'sd0, 5'd1);

    // Random traffic that swings between filling and draining the list.
    grow = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (sb.shadow_cells.size() >= LIST_DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
      else if (sb.shadow_cells.size() == 0 && $urandom_range(0, 1) == 0) grow = 1'b1;
      else if ($urandom_range(0, 59) == 0) grow = !grow;
      random_request(grow);
    end
    req_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("positional_ordered_list regression: pass");
    end else begin
      $display("positional_ordered_list regression: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("positional_ordered_list regression: fail");
    $finish;
  end

endmodule
